@@ sv/otsu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Otsu threshold package
// Shared command, status and multiplier operation types for the Otsu block.
// ----------------------------------------------------------------------------
package otsu_pkg;

   localparam int unsigned NUM_BINS = 256;

   typedef enum logic [2:0] {
      MUL_X,
      MUL_Y,
      MUL_D2,
      MUL_DEN,
      MUL_LHS,
      MUL_RHS
   } mul_op_type;

   typedef struct packed {
      logic       accept;
      logic       rd_bin;
      logic       walk_init;
      logic       add_bin;
      logic       bin_inc;
      logic       mul_start;
      mul_op_type mop;
      logic       cmp;
      logic       emit;
      logic       clr_wr;
   } cmd_type;

   typedef struct packed {
      logic wb_zero;
      logic wb_ge_total;
      logic bin_last;
      logic mul_done;
   } status_type;

endpackage
`default_nettype wire

@@ sv/otsu_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Otsu pixel channel
// Valid/ready channel carrying one grey pixel and its last-of-image flag.
// ----------------------------------------------------------------------------
interface otsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   logic       last;

   modport source (output valid, output pixel, output last, input ready);
   modport sink   (input valid, input pixel, input last, output ready);
endinterface
`default_nettype wire

@@ sv/otsu_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Otsu result channel
// Valid/ready channel carrying one threshold word per image.
// ----------------------------------------------------------------------------
interface otsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] threshold;

   modport source (output valid, output threshold, input ready);
   modport sink   (input valid, input threshold, output ready);
endinterface
`default_nettype wire

@@ sv/otsu_threshold_histogram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Otsu threshold over a pixel stream
// Builds a 256-bin grey histogram and returns the Otsu threshold per image.
// ----------------------------------------------------------------------------
// Pixels enter on the req channel, one word per cycle while req.ready is high.
// A word with last set closes the image: intake stops and the bins are walked
// in order, each bin being read, added and checked and, where it forms a valid
// split, taking six passes of the shared shift-add multiplier, whose b operand
// is XW = 2 * clog2(MAX_PIXELS + 1) + 8 bits wide (50 at the default setting).
// The threshold word is held in an output register on the rsp channel until
// taken; a stalled receiver delays only the following image's result.
// After each result, and after reset, a clearing pass writes zero to every bin,
// during which req.ready is low.
// Pixels beyond MAX_PIXELS are accepted but not counted.
// ----------------------------------------------------------------------------
module otsu_threshold_histogram #(
   parameter int unsigned MAX_PIXELS = 1048576
) (
   input wire logic     clock,
   input wire logic     reset,
   otsu_req_if.sink     req,
   otsu_rsp_if.source   rsp
);

   otsu_pkg::cmd_type    cmd;
   otsu_pkg::status_type st;

   otsu_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req.valid),
      .req_last (req.last),
      .rsp_ready(rsp.ready),
      .st       (st),
      .cmd      (cmd),
      .req_ready(req.ready),
      .rsp_valid(rsp.valid)
   );

   otsu_dp #(
      .MAX_PIXELS(MAX_PIXELS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .pixel    (req.pixel),
      .st       (st),
      .threshold(rsp.threshold)
   );

   a_last_stops_intake: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.last) |=> !req.ready)
      else $error("Intake continued after the last pixel of an image.");

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req.ready)
      else $error("Pixel intake open before the histogram was cleared.");

   a_emit_stops_intake: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!req.ready && !rsp.valid))
      else $error("Result loaded while intake open or a result pending.");

endmodule
`default_nettype wire

@@ sv/otsu_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Otsu shift-add multiplier
// Sequential unsigned multiplier retiring one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module otsu_mul #(
   parameter int unsigned AW = 142,
   parameter int unsigned BW = 50
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [AW-1:0] a,
   input  wire logic [BW-1:0] b,
   output logic               done,
   output logic [AW-1:0]      p
);

   localparam int unsigned CNTW = $clog2(BW + 1);

   logic [AW-1:0]   a_ff;
   logic [BW-1:0]   b_ff;
   logic [AW-1:0]   acc_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            run_ff;
   logic            done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNTW'(BW);
         a_ff    <= a;
         b_ff    <= b;
         acc_ff  <= '0;
      end else if (run_ff) begin
         acc_ff  <= acc_ff + (b_ff[0] ? a_ff : '0);
         a_ff    <= {a_ff[AW-2:0], 1'b0};
         b_ff    <= {1'b0, b_ff[BW-1:1]};
         cnt_ff  <= cnt_ff - 1'b1;
         run_ff  <= (cnt_ff != CNTW'(1));
         done_ff <= (cnt_ff == CNTW'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done = done_ff;
   assign p    = acc_ff;

endmodule
`default_nettype wire

@@ sv/otsu_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Otsu datapath
// Histogram memory, pixel count and sum, and the between-class variance walk.
// ----------------------------------------------------------------------------
module otsu_dp #(
   parameter int unsigned MAX_PIXELS = 1048576
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire otsu_pkg::cmd_type   cmd,
   input  wire logic [7:0]          pixel,
   output otsu_pkg::status_type     st,
   output logic [7:0]               threshold
);

   localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
   localparam int unsigned SW = CW + 8;
   localparam int unsigned XW = SW + CW;
   localparam int unsigned DW = 2 * CW;
   localparam int unsigned NW = 2 * XW;
   localparam int unsigned PW = NW + DW;

   logic [CW-1:0] hist_mem [otsu_pkg::NUM_BINS];

   logic [CW-1:0] rd_ff;
   logic [7:0]    rd_addr;
   logic          wr_en;
   logic [7:0]    wr_addr;
   logic [CW-1:0] wr_data;
   logic [CW-1:0] base;
   logic [CW-1:0] inc_val;

   logic          p1v_ff;
   logic [7:0]    p1a_ff;
   logic          wv_ff;
   logic [7:0]    wa_ff;
   logic [CW-1:0] wd_ff;

   logic [CW-1:0] cnt_ff;
   logic [SW-1:0] sum_ff;
   logic [7:0]    bin_ff;
   logic [CW-1:0] wb_ff;
   logic [SW-1:0] sumb_ff;
   logic [XW-1:0] x_ff;
   logic [XW-1:0] y_ff;
   logic [NW-1:0] num_ff;
   logic [DW-1:0] den_ff;
   logic [PW-1:0] lhs_ff;
   logic [PW-1:0] rhs_ff;
   logic [NW-1:0] bestn_ff;
   logic [DW-1:0] bestd_ff;
   logic [7:0]    thr_ff;
   logic [7:0]    out_ff;

   logic [XW-1:0] diff;
   logic [CW-1:0] wf;
   logic [PW-1:0] mul_a;
   logic [XW-1:0] mul_b;
   logic          mul_done;
   logic [PW-1:0] mul_p;
   logic          sat;

   assign sat     = (cnt_ff >= CW'(MAX_PIXELS));
   assign rd_addr = cmd.rd_bin ? bin_ff : pixel;
   assign base    = (wv_ff && (wa_ff == p1a_ff)) ? wd_ff : rd_ff;
   assign inc_val = base + CW'(1);
   assign wr_en   = p1v_ff | cmd.clr_wr;
   assign wr_addr = cmd.clr_wr ? bin_ff : p1a_ff;
   assign wr_data = cmd.clr_wr ? '0 : inc_val;

   always_ff @(posedge clock) begin
      rd_ff <= hist_mem[rd_addr];
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
   end

   assign diff = (x_ff > y_ff) ? (x_ff - y_ff) : (y_ff - x_ff);
   assign wf   = cnt_ff - wb_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mop)
         otsu_pkg::MUL_X: begin
            mul_a = PW'(sumb_ff);
            mul_b = XW'(cnt_ff);
         end
         otsu_pkg::MUL_Y: begin
            mul_a = PW'(sum_ff);
            mul_b = XW'(wb_ff);
         end
         otsu_pkg::MUL_D2: begin
            mul_a = PW'(diff);
            mul_b = diff;
         end
         otsu_pkg::MUL_DEN: begin
            mul_a = PW'(wb_ff);
            mul_b = XW'(wf);
         end
         otsu_pkg::MUL_LHS: begin
            mul_a = PW'(num_ff);
            mul_b = XW'(bestd_ff);
         end
         otsu_pkg::MUL_RHS: begin
            mul_a = PW'(bestn_ff);
            mul_b = XW'(den_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   otsu_mul #(
      .AW(PW),
      .BW(XW)
   ) u_mul (
      .clock(clock),
      .reset(reset),
      .start(cmd.mul_start),
      .a    (mul_a),
      .b    (mul_b),
      .done (mul_done),
      .p    (mul_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         p1v_ff <= 1'b0;
         wv_ff  <= 1'b0;
         cnt_ff <= '0;
         sum_ff <= '0;
         bin_ff <= '0;
      end else begin
         p1v_ff <= cmd.accept && !sat;
         if (cmd.emit) begin
            wv_ff  <= 1'b0;
            cnt_ff <= '0;
            sum_ff <= '0;
         end else begin
            if (p1v_ff) begin
               wv_ff <= 1'b1;
            end
            if (cmd.accept && !sat) begin
               cnt_ff <= cnt_ff + CW'(1);
               sum_ff <= sum_ff + SW'(pixel);
            end
         end
         if (cmd.walk_init || cmd.emit) begin
            bin_ff <= '0;
         end else if (cmd.bin_inc || cmd.clr_wr) begin
            bin_ff <= bin_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      p1a_ff <= pixel;
      if (p1v_ff) begin
         wa_ff <= p1a_ff;
         wd_ff <= inc_val;
      end
      if (cmd.walk_init) begin
         wb_ff    <= '0;
         sumb_ff  <= '0;
         bestn_ff <= '0;
         bestd_ff <= DW'(1);
         thr_ff   <= '0;
      end
      if (cmd.add_bin) begin
         wb_ff   <= wb_ff + rd_ff;
         sumb_ff <= sumb_ff + SW'(SW'(rd_ff) * SW'(bin_ff));
      end
      if (mul_done) begin
         case (cmd.mop)
            otsu_pkg::MUL_X:   x_ff   <= mul_p[XW-1:0];
            otsu_pkg::MUL_Y:   y_ff   <= mul_p[XW-1:0];
            otsu_pkg::MUL_D2:  num_ff <= mul_p[NW-1:0];
            otsu_pkg::MUL_DEN: den_ff <= mul_p[DW-1:0];
            otsu_pkg::MUL_LHS: lhs_ff <= mul_p;
            otsu_pkg::MUL_RHS: rhs_ff <= mul_p;
            default:           x_ff   <= x_ff;
         endcase
      end
      if (cmd.cmp && (lhs_ff > rhs_ff)) begin
         bestn_ff <= num_ff;
         bestd_ff <= den_ff;
         thr_ff   <= bin_ff;
      end
      if (cmd.emit) begin
         out_ff <= thr_ff;
      end
   end

   assign st.wb_zero     = (wb_ff == '0);
   assign st.wb_ge_total = (wb_ff >= cnt_ff);
   assign st.bin_last    = (bin_ff == 8'd255);
   assign st.mul_done    = mul_done;
   assign threshold      = out_ff;

endmodule
`default_nettype wire

@@ sv/otsu_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Otsu controller
// Sequences pixel intake, the bin walk, result hand-off and histogram clear.
// ----------------------------------------------------------------------------
module otsu_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_last,
   input  wire logic                 rsp_ready,
   input  wire otsu_pkg::status_type st,
   output otsu_pkg::cmd_type         cmd,
   output logic                      req_ready,
   output logic                      rsp_valid
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_RUN,
      S_DRAIN,
      S_RD,
      S_ADD,
      S_CHK,
      S_MSTART,
      S_MWAIT,
      S_CMP,
      S_EMIT
   } state_type;

   state_type            state_ff;
   otsu_pkg::mul_op_type op_ff;
   logic                 rsp_valid_ff;
   logic                 accept;

   assign req_ready = (state_ff == S_RUN);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.mop       = op_ff;
      cmd.accept    = accept;
      cmd.clr_wr    = (state_ff == S_CLEAR);
      cmd.walk_init = (state_ff == S_DRAIN);
      cmd.rd_bin    = (state_ff == S_RD) || (state_ff == S_CLEAR);
      cmd.add_bin   = (state_ff == S_ADD);
      cmd.mul_start = (state_ff == S_MSTART);
      cmd.cmp       = (state_ff == S_CMP);
      cmd.emit      = (state_ff == S_EMIT) && !rsp_valid_ff;
      cmd.bin_inc   = ((state_ff == S_CHK) && st.wb_zero && !st.bin_last) ||
                      ((state_ff == S_CMP) && !st.bin_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         op_ff        <= otsu_pkg::MUL_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               if (st.bin_last) begin
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               if (accept && req_last) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: state_ff <= S_RD;
            S_RD:    state_ff <= S_ADD;
            S_ADD:   state_ff <= S_CHK;
            S_CHK: begin
               if (st.wb_zero) begin
                  state_ff <= st.bin_last ? S_EMIT : S_RD;
               end else if (st.wb_ge_total) begin
                  state_ff <= S_EMIT;
               end else begin
                  op_ff    <= otsu_pkg::MUL_X;
                  state_ff <= S_MSTART;
               end
            end
            S_MSTART: state_ff <= S_MWAIT;
            S_MWAIT: begin
               if (st.mul_done) begin
                  case (op_ff)
                     otsu_pkg::MUL_X:   op_ff <= otsu_pkg::MUL_Y;
                     otsu_pkg::MUL_Y:   op_ff <= otsu_pkg::MUL_D2;
                     otsu_pkg::MUL_D2:  op_ff <= otsu_pkg::MUL_DEN;
                     otsu_pkg::MUL_DEN: op_ff <= otsu_pkg::MUL_LHS;
                     otsu_pkg::MUL_LHS: op_ff <= otsu_pkg::MUL_RHS;
                     default:           op_ff <= otsu_pkg::MUL_X;
                  endcase
                  state_ff <= (op_ff == otsu_pkg::MUL_RHS) ? S_CMP : S_MSTART;
               end
            end
            S_CMP: state_ff <= st.bin_last ? S_EMIT : S_RD;
            S_EMIT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_CLEAR;
               end
            end
            default: state_ff <= S_CLEAR;
         endcase
      end
   end

endmodule
`default_nettype wire
